// ===== rtl/ofla_pkg.sv =====
// ----------------------------------------------------------------------------
// ofla_pkg
// Shared constants for the offset free-list allocator: operation codes,
// status codes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package ofla_pkg;

  localparam int unsigned DEF_MAX_RANGES  = 32;
  localparam int unsigned DEF_OFFSET_BITS = 32;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic CFG_FIT_POLICY = 1'b0;
  localparam logic CFG_POOL_SIZE  = 1'b1;

  localparam logic FIT_FIRST = 1'b0;

  localparam logic [31:0] POOL_SIZE_RESET = 32'd65536;

endpackage

`default_nettype wire

// ===== rtl/ofla_mem.sv =====
// ----------------------------------------------------------------------------
// ofla_mem
// Free-range table storage: one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ofla_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 65
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ofla_fit.sv =====
// ----------------------------------------------------------------------------
// ofla_fit
// First stage of the allocate scan: rounds a range's start up to the
// requested alignment and registers the aligned start and padding.
// ----------------------------------------------------------------------------
`default_nettype none

module ofla_fit #(
  parameter int unsigned MAX_RANGES  = 32,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          flush,
  input  wire logic                          in_v,
  input  wire logic [$clog2(MAX_RANGES)-1:0] in_idx,
  input  wire logic [OFFSET_BITS:0]          ent_start,
  input  wire logic [OFFSET_BITS-1:0]        ent_len,
  input  wire logic [4:0]                    shift,
  output logic                               a_v,
  output logic      [$clog2(MAX_RANGES)-1:0] a_idx,
  output logic                               a_ok,
  output logic      [OFFSET_BITS+32:0]       a_al,
  output logic      [OFFSET_BITS+32:0]       a_pad,
  output logic      [OFFSET_BITS-1:0]        a_len
);

  localparam int unsigned EW = OFFSET_BITS + 33;
  localparam logic [EW-1:0] OMASK_E = {{(EW-OFFSET_BITS){1'b0}}, {OFFSET_BITS{1'b1}}};

  logic [EW-1:0] amask;
  logic [EW-1:0] s_e;
  logic [EW-1:0] sa;
  logic          aligned0;
  logic          ovf;
  logic [EW-1:0] al;

  always_comb begin
    amask    = (EW'(1) << shift) - EW'(1);
    s_e      = EW'(ent_start);
    sa       = s_e + amask;
    aligned0 = (s_e & amask) == '0;
    // A mask wider than the offset space wraps the overflow test, so it
    // only applies when the mask itself fits.
    ovf      = (amask <= OMASK_E) && (sa > OMASK_E);
    al       = aligned0 ? s_e : (sa & ~amask);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v <= 1'b0;
    end else begin
      a_v <= in_v && !flush;
    end
  end

  always_ff @(posedge clk) begin
    a_idx <= in_idx;
    a_ok  <= aligned0 || !ovf;
    a_al  <= al;
    a_pad <= al - s_e;
    a_len <= ent_len;
  end

endmodule

`default_nettype wire

// ===== rtl/offset_free_list_allocator.sv =====
// Allocate: one table read per cycle through two evaluation stages; an exact
//   fit then closes the hole by moving each later entry down one slot.
// Free: one table entry per cycle through a single insert-and-merge sweep.
// List reset and no-operation go straight to the result state.
// One word at a time; the single read port of the table sets the pace.
// Reset: synchronous; the first state after reset writes the single free range.
// ----------------------------------------------------------------------------
// offset_free_list_allocator
// Free-range allocator with first-fit or best-fit policy and coalescing.
// ----------------------------------------------------------------------------
`default_nettype none

module offset_free_list_allocator #(
  parameter int unsigned MAX_RANGES  = ofla_pkg::DEF_MAX_RANGES,
  parameter int unsigned OFFSET_BITS = ofla_pkg::DEF_OFFSET_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_req_size,
  input  wire logic [4:0]  in_align_shift,
  input  wire logic [31:0] in_free_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [1:0]  out_status,
  output logic      [31:0] out_alloc_offset,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  import ofla_pkg::*;

  localparam int unsigned OB  = OFFSET_BITS;
  localparam int unsigned SW  = OB + 1;
  localparam int unsigned SW1 = SW + 1;
  localparam int unsigned EW  = OB + 33;
  localparam int unsigned IW  = $clog2(MAX_RANGES);
  localparam int unsigned CW  = $clog2(MAX_RANGES + 1);
  localparam int unsigned DW  = SW + OB;
  localparam logic [SW1-1:0] OMASK_S = {{(SW1-OB){1'b0}}, {OB{1'b1}}};
  localparam logic [CW-1:0]  MAXC    = CW'(MAX_RANGES);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_MERGE = 3'd4;
  localparam logic [2:0] S_MTAIL = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          v1_r, v1_nxt;
  logic [IW-1:0] idx1_r, idx1_nxt;
  logic [OB-1:0] size_r, foff_r;
  logic [4:0]    shift_r;
  logic          found_r, found_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [OB-1:0] best_waste_r, best_waste_nxt;
  logic [EW-1:0] best_al_r, best_al_nxt;
  logic          cur_v_r, cur_v_nxt;
  logic [SW-1:0] cur_s_r, cur_s_nxt;
  logic [OB-1:0] cur_l_r, cur_l_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic          ins_done_r, ins_done_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [31:0]   out_off_r, out_off_nxt;
  logic          fit_pol_r;
  logic [31:0]   pool_r;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  logic [SW-1:0] rd_start;
  logic [OB-1:0] rd_len;

  logic          a_v, a_ok;
  logic [IW-1:0] a_idx;
  logic [EW-1:0] a_al, a_pad;
  logic [OB-1:0] a_len;
  logic          fit_flush;

  logic [EW-1:0] len_e, size_e;
  logic          fit_b, take;
  logic [OB-1:0] waste_b;
  logic          scan_done;

  logic          ins_now, proc_en, adj;
  logic [SW-1:0] e_s;
  logic [OB-1:0] e_l;
  logic [SW1-1:0] end_sum;
  logic [OB:0]   lsum;
  logic [OB-1:0] merged_l;

  assign rd_start = mem_rdata[DW-1:OB];
  assign rd_len   = mem_rdata[OB-1:0];

  ofla_mem #(
    .DEPTH (MAX_RANGES),
    .WIDTH (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ofla_fit #(
    .MAX_RANGES  (MAX_RANGES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_fit (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (fit_flush),
    .in_v      (v1_r),
    .in_idx    (idx1_r),
    .ent_start (rd_start),
    .ent_len   (rd_len),
    .shift     (shift_r),
    .a_v       (a_v),
    .a_idx     (a_idx),
    .a_ok      (a_ok),
    .a_al      (a_al),
    .a_pad     (a_pad),
    .a_len     (a_len)
  );

  // Second scan stage: fit test and leftover of the candidate.
  always_comb begin
    len_e   = EW'(a_len);
    size_e  = EW'(size_r);
    fit_b   = a_v && a_ok && (a_pad <= len_e) && (size_e <= len_e - a_pad);
    waste_b = OB'(len_e - a_pad - size_e);
    take    = fit_b && (!found_r || (fit_pol_r != FIT_FIRST && waste_b < best_waste_r));
    scan_done = (fit_pol_r == FIT_FIRST && found_r) ||
                (k_r >= count_r && !v1_r && !a_v);
    fit_flush = (state_r != S_SCAN) || scan_done;
  end

  // Next element of the free sweep: the freed range goes in front of the
  // first stored range that starts beyond it.
  always_comb begin
    ins_now  = 1'b0;
    if (state_r == S_MERGE) begin
      ins_now = !ins_done_r && (rd_start > SW'(foff_r));
    end else if (state_r == S_MTAIL) begin
      ins_now = !ins_done_r;
    end
    proc_en  = (state_r == S_MERGE) || (state_r == S_MTAIL && !ins_done_r);
    e_s      = ins_now ? SW'(foff_r) : rd_start;
    e_l      = ins_now ? size_r : rd_len;
    end_sum  = SW1'(cur_s_r) + SW1'(cur_l_r);
    adj      = cur_v_r && (end_sum <= OMASK_S) && (end_sum == SW1'(e_s));
    lsum     = (OB+1)'(cur_l_r) + (OB+1)'(e_l);
    merged_l = lsum[OB] ? {OB{1'b1}} : lsum[OB-1:0];
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    v1_nxt         = 1'b0;
    idx1_nxt       = idx1_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_waste_nxt = best_waste_r;
    best_al_nxt    = best_al_r;
    cur_v_nxt      = cur_v_r;
    cur_s_nxt      = cur_s_r;
    cur_l_nxt      = cur_l_r;
    w_nxt          = w_r;
    ins_done_nxt   = ins_done_r;
    res_st_nxt     = res_st_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;

    if (proc_en) begin
      if (!cur_v_r) begin
        cur_v_nxt = 1'b1;
        cur_s_nxt = e_s;
        cur_l_nxt = e_l;
      end else if (adj) begin
        cur_l_nxt = merged_l;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = IW'(w_r);
        mem_wdata = {cur_s_r, cur_l_r};
        w_nxt     = w_r + CW'(1);
        cur_s_nxt = e_s;
        cur_l_nxt = e_l;
      end
    end

    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {{SW{1'b0}}, OB'(pool_r)};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          res_st_nxt  = ST_OK;
          found_nxt   = 1'b0;
          best_al_nxt = '0;
          case (in_mode)
            MODE_ALLOC: begin
              k_nxt     = '0;
              state_nxt = S_SCAN;
            end
            MODE_FREE: begin
              cur_v_nxt    = 1'b0;
              w_nxt        = '0;
              ins_done_nxt = 1'b0;
              k_nxt        = '0;
              if (count_r >= MAXC) begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_FIN;
              end else if (count_r != '0) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_nxt = S_MERGE;
              end else begin
                state_nxt = S_MTAIL;
              end
            end
            MODE_RESET: begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = {{SW{1'b0}}, OB'(pool_r)};
              count_nxt = CW'(1);
              state_nxt = S_FIN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (take) begin
          found_nxt      = 1'b1;
          best_idx_nxt   = a_idx;
          best_waste_nxt = waste_b;
          best_al_nxt    = a_al;
        end
        if (scan_done) begin
          if (!found_r) begin
            res_st_nxt = ST_NOFIT;
            state_nxt  = S_FIN;
          end else if (best_waste_r == '0) begin
            if (CW'(best_idx_r) + CW'(1) < count_r) begin
              mem_re    = 1'b1;
              mem_raddr = best_idx_r + IW'(1);
              k_nxt     = CW'(best_idx_r) + CW'(1);
              state_nxt = S_SHIFT;
            end else begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_FIN;
            end
          end else begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_r;
            mem_wdata = {SW'(best_al_r + EW'(size_r)), best_waste_r};
            state_nxt = S_FIN;
          end
        end else if (k_r < count_r && !(fit_pol_r == FIT_FIRST && take)) begin
          mem_re    = 1'b1;
          mem_raddr = IW'(k_r);
          idx1_nxt  = IW'(k_r);
          v1_nxt    = 1'b1;
          k_nxt     = k_r + CW'(1);
        end
      end
      S_SHIFT: begin
        // Close the hole left by an exact fit, one entry per cycle.
        mem_we    = 1'b1;
        mem_waddr = IW'(k_r - CW'(1));
        mem_wdata = mem_rdata;
        if (k_r + CW'(1) < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = IW'(k_r + CW'(1));
          k_nxt     = k_r + CW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_FIN;
        end
      end
      S_MERGE: begin
        if (ins_now) begin
          ins_done_nxt = 1'b1;
        end else if (k_r + CW'(1) < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = IW'(k_r + CW'(1));
          k_nxt     = k_r + CW'(1);
        end else begin
          state_nxt = S_MTAIL;
        end
      end
      S_MTAIL: begin
        if (!ins_done_r) begin
          ins_done_nxt = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = IW'(w_r);
          mem_wdata = {cur_s_r, cur_l_r};
          count_nxt = w_r + CW'(1);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_st_r;
          out_off_nxt    = (res_st_r == ST_OK) ? 32'(best_al_r) : 32'd0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CW'(1);
      k_r         <= '0;
      v1_r        <= 1'b0;
      found_r     <= 1'b0;
      cur_v_r     <= 1'b0;
      w_r         <= '0;
      ins_done_r  <= 1'b0;
      res_st_r    <= ST_OK;
      out_valid_r <= 1'b0;
      fit_pol_r   <= FIT_FIRST;
      pool_r      <= POOL_SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      v1_r        <= v1_nxt;
      found_r     <= found_nxt;
      cur_v_r     <= cur_v_nxt;
      w_r         <= w_nxt;
      ins_done_r  <= ins_done_nxt;
      res_st_r    <= res_st_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIT_POLICY: fit_pol_r <= cfg_wdata[0];
          CFG_POOL_SIZE:  pool_r    <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1_r       <= idx1_nxt;
    best_idx_r   <= best_idx_nxt;
    best_waste_r <= best_waste_nxt;
    best_al_r    <= best_al_nxt;
    cur_s_r      <= cur_s_nxt;
    cur_l_r      <= cur_l_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
    if (state_r == S_IDLE && in_valid) begin
      size_r  <= OB'(in_req_size);
      foff_r  <= OB'(in_free_offset);
      shift_r <= in_align_shift;
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_alloc_offset = out_off_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAXC)
    else $error("range count exceeds table depth");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_st_r == ST_FULL) |-> count_r == MAXC)
    else $error("table-full status with room left");

  a_shift_exact_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (found_r && best_waste_r == '0))
    else $error("entry removal without an exact fit");

endmodule

`default_nettype wire

// ===== verif/offset_free_list_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// offset_free_list_allocator_tb
// Drives allocate, free, list reset and idle words into the allocator under
// both fit policies and several pool sizes. A shadow free-range table
// predicts each status and offset, and every result word is checked in order.
// ----------------------------------------------------------------------------

module offset_free_list_allocator_tb;
  import ofla_pkg::*;

  localparam int unsigned NRANGES = 32;
  localparam logic [63:0] TOP = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] size;
    logic [4:0]  shift;
    logic [31:0] offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] offset;
  } grant_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_mode;
  logic [31:0] in_req_size, in_free_offset;
  logic [4:0] in_align_shift;
  logic out_valid, out_ready;
  logic [1:0] out_status;
  logic [31:0] out_alloc_offset;
  logic cfg_we, cfg_index;
  logic [31:0] cfg_wdata;

  offset_free_list_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_req_size(in_req_size), .in_align_shift(in_align_shift),
    .in_free_offset(in_free_offset),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_alloc_offset(out_alloc_offset),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the block's state. A shrunk range can start past the top of
  // the offset space, so starts are kept wide.
  logic        fit_best;
  logic [31:0] pool_bytes;
  logic [63:0] rstart [NRANGES];
  logic [63:0] rlen   [NRANGES];
  int unsigned rcount;

  req_t   pending_reqs[$];
  grant_t expected_grants[$];
  int     errors = 0;
  longint cycle = 0;
  int     hold_off = 0;
  bit     stim_done = 0;
  int     sent_count = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void clear_table();
    for (int k = 0; k < NRANGES; k++) begin
      rstart[k] = 0;
      rlen[k] = 0;
    end
    rlen[0] = 64'(pool_bytes);
    rcount = 1;
  endfunction

  function automatic void drop_range(int unsigned idx);
    for (int unsigned k = idx; k + 1 < rcount; k++) begin
      rstart[k] = rstart[k+1];
      rlen[k] = rlen[k+1];
    end
    rcount--;
    rstart[rcount] = 0;
    rlen[rcount] = 0;
  endfunction

  function automatic grant_t allocate_range(logic [31:0] size, logic [4:0] shift);
    grant_t g;
    logic [63:0] a, al, pad, waste, bwaste, bal, bpad, sz;
    int unsigned best;
    bit found;
    g = '0;
    found = 0; best = 0; bwaste = 0; bal = 0; bpad = 0;
    sz = 64'(size);
    a = (64'd1 << shift) - 64'd1;
    for (int unsigned i = 0; i < rcount; i++) begin
      if ((rstart[i] & a) == 0) al = rstart[i];
      else if (rstart[i] > TOP - a) continue;
      else al = (rstart[i] + a) & ~a;
      pad = al - rstart[i];
      if (pad > rlen[i] || sz > rlen[i] - pad) continue;
      waste = rlen[i] - pad - sz;
      if (!found || (fit_best && waste < bwaste)) begin
        found = 1; best = i; bwaste = waste; bal = al; bpad = pad;
      end
      if (!fit_best) break;
    end
    if (!found) begin
      g.status = ST_NOFIT;
      return g;
    end
    if (bwaste == 0) drop_range(best);
    else begin
      rstart[best] = rstart[best] + bpad + sz;
      rlen[best] = bwaste;
    end
    g.status = ST_OK;
    g.offset = bal[31:0];
    return g;
  endfunction

  function automatic logic [1:0] free_range(logic [31:0] off, logic [31:0] len);
    int unsigned pos, i;
    logic [63:0] s, l, nl;
    if (rcount >= NRANGES) return ST_FULL;
    pos = 0;
    while (pos < rcount && rstart[pos] <= 64'(off)) pos++;
    for (int unsigned k = rcount; k > pos; k--) begin
      rstart[k] = rstart[k-1];
      rlen[k] = rlen[k-1];
    end
    rstart[pos] = 64'(off);
    rlen[pos] = 64'(len);
    rcount++;
    i = 0;
    while (i + 1 < rcount) begin
      s = rstart[i]; l = rlen[i];
      if (s <= TOP - l && s + l == rstart[i+1]) begin
        nl = rlen[i+1];
        rlen[i] = (l > TOP - nl) ? TOP : l + nl;
        drop_range(i + 1);
      end else i++;
    end
    return ST_OK;
  endfunction

  function automatic grant_t predict_grant(req_t r);
    grant_t g;
    g = '0;
    case (r.mode)
      MODE_ALLOC: g = allocate_range(r.size, r.shift);
      MODE_FREE:  g.status = free_range(r.offset, r.size);
      MODE_RESET: clear_table();
      default: ;
    endcase
    return g;
  endfunction

  // Driver.
  always @(posedge clk) begin
    req_t r;
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (pending_reqs.size() > 0 && ($urandom_range(0, 3) != 0 || hold_off > 0)) begin
        r = pending_reqs.pop_front();
        expected_grants = {expected_grants, predict_grant(r)};
        in_valid <= 1;
        in_mode <= r.mode;
        in_req_size <= r.size;
        in_align_shift <= r.shift;
        in_free_offset <= r.offset;
        sent_count <= sent_count + 1;
      end else if ($urandom_range(0, 40) == 0 && pending_reqs.size() > 0) begin
        in_valid <= 0;
        repeat ($urandom_range(5, 60)) @(posedge clk);
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Monitor and result-side stalls.
  always @(posedge clk) begin
    grant_t e;
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected word status=%0d offset=%h", $time,
                   out_status, out_alloc_offset);
          errors++;
        end else begin
          e = expected_grants.pop_front();
          if (out_status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
            errors++;
          end
          if (out_alloc_offset !== e.offset) begin
            $display("%0t: offset expected %h actual %h", $time, e.offset,
                     out_alloc_offset);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 0;
      end else if ($urandom_range(0, 99) == 0) begin
        hold_off <= $urandom_range(20, 120);
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic add_req(logic [1:0] m, logic [31:0] sz, logic [4:0] sh, logic [31:0] off);
    req_t r;
    r.mode = m; r.size = sz; r.shift = sh; r.offset = off;
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_grants.size() > 0 || in_valid)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_FIT_POLICY) fit_best = val[0];
    else pool_bytes = val;
  endtask

  // Mostly small allocations and frees, the frees at random offsets.
  task automatic random_phase(int n);
    logic [31:0] granted[$];
    logic [31:0] o, sz;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      sz = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 600);
      if (pick < 45) begin
        add_req(MODE_ALLOC, sz, $urandom_range(0, 9) == 0 ? 5'($urandom_range(0, 31))
                : 5'($urandom_range(0, 6)), $urandom());
        granted = {granted, 32'($urandom_range(0, 65535))};
      end else if (pick < 85) begin
        o = (granted.size() > 0 && $urandom_range(0, 3) != 0) ?
            granted[$urandom_range(0, granted.size() - 1)] : $urandom();
        add_req(MODE_FREE, sz, 5'($urandom()), o);
      end else if (pick < 92) begin
        add_req(MODE_NOP, $urandom(), 5'($urandom()), $urandom());
      end else if (pick < 95) begin
        add_req(MODE_RESET, $urandom(), 5'($urandom()), $urandom());
      end else begin
        add_req(MODE_FREE, $urandom_range(1, 64), 0, 32'($urandom_range(0, 1023)) << 6);
      end
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_mode = 0; in_req_size = 0; in_align_shift = 0; in_free_offset = 0;
    out_ready = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    fit_best = FIT_FIRST;
    pool_bytes = POOL_SIZE_RESET;
    clear_table();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    repeat (4) @(posedge clk);

    // Directed: extremes, zero request, alignment overflow, full table.
    add_req(MODE_ALLOC, 0, 0, 0);
    add_req(MODE_ALLOC, 100, 4, 0);
    add_req(MODE_ALLOC, 0, 16, 0);
    add_req(MODE_ALLOC, 32'hFFFF_FFFF, 0, 0);
    add_req(MODE_ALLOC, 10, 31, 0);
    add_req(MODE_FREE, 16, 0, 0);
    add_req(MODE_FREE, 16, 0, 0);
    add_req(MODE_FREE, 32'hFFFF_FFFF, 0, 32'hFFFF_FFF0);
    add_req(MODE_NOP, 32'hFFFF_FFFF, 5'h1F, 32'hFFFF_FFFF);
    add_req(MODE_RESET, 0, 0, 0);
    for (int k = 0; k < 34; k++) add_req(MODE_FREE, 1, 0, 32'h0002_0000 + 2 * k);
    add_req(MODE_ALLOC, 1, 1, 0);
    drain();

    write_reg(CFG_FIT_POLICY, 1);
    write_reg(CFG_POOL_SIZE, 32'hFFFF_FFFF);
    add_req(MODE_RESET, 0, 0, 0);
    add_req(MODE_ALLOC, 32'h1000_0000, 3, 0);
    add_req(MODE_FREE, 32'h10, 0, 32'hFFFF_FFF8);
    add_req(MODE_ALLOC, 8, 2, 0);
    add_req(MODE_ALLOC, 32'hFFFF_FFFF, 0, 0);
    drain();

    write_reg(CFG_POOL_SIZE, 0);
    add_req(MODE_RESET, 0, 0, 0);
    add_req(MODE_ALLOC, 0, 0, 0);
    add_req(MODE_ALLOC, 1, 0, 0);
    drain();

    // Random phases over a range of settings.
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_FIT_POLICY, p[0]);
      write_reg(CFG_POOL_SIZE, p == 5 ? 32'hFFFF_FFFF : p == 4 ? 32'd200 : $urandom_range(1000, 70000));
      add_req(MODE_RESET, 0, 0, 0);
      random_phase(230);
      drain();
    end
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
